// ===== design/acs_pkg.sv =====
package acs_pkg;

  // channel index and mux code width
  localparam int unsigned CHAN_W = 4;

  localparam logic [CHAN_W-1:0] SMOOTH_CH  = 4'd7;
  localparam logic [CHAN_W-1:0] TEMP_CH    = 4'd8;
  localparam logic [CHAN_W-1:0] MUX_OFFSET = 4'd5;

  // enable mask after reset: smoothed channel only
  localparam logic [15:0] ENABLE_RESET = 16'd128;

  // request kinds
  localparam logic OP_CONVERT = 1'b0;
  localparam logic OP_READ    = 1'b1;

  // shared unit operations
  typedef enum logic {
    MODE_SMOOTH,
    MODE_STEP
  } step_mode_e;

  // converter mux code, wraps to four bits above the temperature channel
  function automatic logic [CHAN_W-1:0] mux_code(input logic [CHAN_W-1:0] ch);
    logic [CHAN_W-1:0] code;
    if (ch <= TEMP_CH) begin
      code = ch;
    end else begin
      code = ch + MUX_OFFSET;
    end
    return code;
  endfunction

endpackage

// ===== design/acs_step_unit.sv =====
module acs_step_unit #(
  parameter int unsigned NUM_CHANNELS = 11,
  parameter int unsigned SAMPLE_BITS  = 10
) (
  input  acs_pkg::step_mode_e     mode_i,
  input  logic [SAMPLE_BITS-1:0]  a_i,
  input  logic [SAMPLE_BITS-1:0]  b_i,
  output logic [SAMPLE_BITS-1:0]  result_o
);
  import acs_pkg::*;

  localparam int unsigned AccW = SAMPLE_BITS + 3;

  logic [AccW-1:0]        acc;
  logic [SAMPLE_BITS-1:0] inc;

  // a + 7*b as a + 8*b - b, then divide by eight
  assign acc = {3'b000, a_i} + {b_i, 3'b000} - {3'b000, b_i};
  assign inc = a_i + SAMPLE_BITS'(1);

  always_comb begin
    case (mode_i)
      MODE_SMOOTH: result_o = acc[AccW-1:3];
      MODE_STEP: begin
        if (a_i == SAMPLE_BITS'(NUM_CHANNELS - 1)) begin
          result_o = '0;
        end else begin
          result_o = inc;
        end
      end
      default: result_o = '0;
    endcase
  end

endmodule

// ===== design/adc_channel_scanner_with_ema_unit.sv =====
// adc scan sequencer with a running average on the smoothed channel
//
// request channel (in_valid_i / in_stall_o): op_i = 0 delivers a finished
// conversion in sample_i for the channel now being converted; op_i = 1 asks
// for the stored result of read_channel_i. every request gives exactly one
// response on the output channel (out_valid_o / out_stall_i) carrying the
// mux code and index of the channel now converted, the read data and the
// scan_stalled flag (set when a conversion found an empty enable mask).
//
// a read goes straight to the done state, which loads the output register; a
// conversion passes the smooth state, the scan state while it steps over 1 to
// NUM_CHANNELS channels to the next enabled one, and the done state; an empty
// mask skips the scan. the shared step unit scans one channel per cycle.
// in_stall_o is high while a request is in progress, until it loads the output
// register. a stalled response sits in the output register; one more request
// may be accepted meanwhile and its response waits for the slot. reset clears
// the stored results and the average, selects channel 0 and enables the
// smoothed channel only. channel_enable takes a write whenever cfg_valid_i
// is high (ready is always high); the user must write it only while no
// request is busy, and the block itself does not enforce this.
module adc_channel_scanner_with_ema_unit #(
  parameter int unsigned NUM_CHANNELS = 11,
  parameter int unsigned SAMPLE_BITS  = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        op_i,
  input  logic [SAMPLE_BITS-1:0]      sample_i,
  input  logic [acs_pkg::CHAN_W-1:0]  read_channel_i,
  // response channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [acs_pkg::CHAN_W-1:0]  mux_select_o,
  output logic [acs_pkg::CHAN_W-1:0]  next_channel_o,
  output logic [SAMPLE_BITS-1:0]      read_data_o,
  output logic                        scan_stalled_o,
  // configuration write channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [NUM_CHANNELS-1:0]     cfg_channel_enable_i
);
  import acs_pkg::*;

  localparam int unsigned IdxW = $clog2(NUM_CHANNELS);

  // sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SMOOTH = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  logic [1:0]              state_q, state_d;
  logic                    op_q;
  logic [SAMPLE_BITS-1:0]  sample_q;
  logic [SAMPLE_BITS-1:0]  rdata_q;
  logic                    stalled_q;
  logic [CHAN_W-1:0]       cur_q;
  logic [SAMPLE_BITS-1:0]  smooth_q;
  logic [NUM_CHANNELS-1:0] en_q;
  logic [SAMPLE_BITS-1:0]  res_q [NUM_CHANNELS];

  logic                    out_valid_q;
  logic [CHAN_W-1:0]       mux_q;
  logic [CHAN_W-1:0]       next_q;
  logic [SAMPLE_BITS-1:0]  out_data_q;
  logic                    out_stalled_q;

  logic                    accept;
  logic                    rd_in_range;
  logic                    out_free;
  logic                    out_load;
  step_mode_e              unit_mode;
  logic [SAMPLE_BITS-1:0]  unit_a;
  logic [SAMPLE_BITS-1:0]  unit_res;
  logic [SAMPLE_BITS-1:0]  store_val;
  logic [CHAN_W-1:0]       step_ch;

  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign rd_in_range = ({1'b0, read_channel_i} < (CHAN_W + 1)'(NUM_CHANNELS));
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = (state_q == ST_DONE) && out_free;

  // shared unit: running average in the smooth step, channel increment in the scan
  assign unit_mode = (state_q == ST_SMOOTH) ? MODE_SMOOTH : MODE_STEP;
  assign unit_a    = (state_q == ST_SMOOTH) ? sample_q : SAMPLE_BITS'(cur_q);

  acs_step_unit #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_step (
    .mode_i   (unit_mode),
    .a_i      (unit_a),
    .b_i      (smooth_q),
    .result_o (unit_res)
  );

  assign store_val = (cur_q == SMOOTH_CH) ? unit_res : sample_q;
  assign step_ch   = unit_res[CHAN_W-1:0];

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (op_i == OP_READ) ? ST_DONE : ST_SMOOTH;
        end
      end
      ST_SMOOTH: begin
        // empty mask keeps the channel and flags the stall
        state_d = (en_q == '0) ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        if (en_q[step_ch[IdxW-1:0]]) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cur_q     <= '0;
      smooth_q  <= '0;
      en_q      <= ENABLE_RESET[NUM_CHANNELS-1:0];
      stalled_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        en_q <= cfg_channel_enable_i;
      end
      if (accept) begin
        stalled_q <= 1'b0;
      end
      if (state_q == ST_SMOOTH) begin
        if (cur_q == SMOOTH_CH) begin
          smooth_q <= unit_res;
        end
        if (en_q == '0) begin
          stalled_q <= 1'b1;
        end
      end
      // scan walks the channel register until an enabled one is hit
      if (state_q == ST_SCAN) begin
        cur_q <= step_ch;
      end
    end
  end

  // request capture and read port of the result store
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= op_i;
      sample_q <= sample_i;
      if (rd_in_range) begin
        rdata_q <= res_q[read_channel_i[IdxW-1:0]];
      end else begin
        rdata_q <= '0;
      end
    end
  end

  // per-channel result store, one write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        res_q[i] <= '0;
      end
    end else if (state_q == ST_SMOOTH) begin
      res_q[cur_q[IdxW-1:0]] <= store_val;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      mux_q         <= mux_code(cur_q);
      next_q        <= cur_q;
      out_data_q    <= (op_q == OP_READ) ? rdata_q : '0;
      out_stalled_q <= stalled_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign mux_select_o   = mux_q;
  assign next_channel_o = next_q;
  assign read_data_o    = out_data_q;
  assign scan_stalled_o = out_stalled_q;

endmodule

// ===== design/acs_checker.sv =====
module acs_checker #(
  parameter int unsigned NUM_CHANNELS = 11,
  parameter int unsigned SAMPLE_BITS  = 10
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [acs_pkg::CHAN_W-1:0]  mux_select_o,
  input logic [acs_pkg::CHAN_W-1:0]  next_channel_o,
  input logic [SAMPLE_BITS-1:0]      read_data_o
);
  import acs_pkg::*;

  // a request keeps the block busy in the cycle after it is accepted
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted without going busy");

  // held response stays valid and keeps its channel and read data
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(next_channel_o)
      && $stable(read_data_o))
    else $error("stalled response changed");

  // reported channel stays inside the scan range
  a_chan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, next_channel_o} < (CHAN_W + 1)'(NUM_CHANNELS)))
    else $error("channel out of range");

  // mux code matches the reported channel
  a_mux_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (mux_select_o == mux_code(next_channel_o)))
    else $error("mux code does not match channel");

endmodule

bind adc_channel_scanner_with_ema_unit acs_checker #(
  .NUM_CHANNELS (NUM_CHANNELS),
  .SAMPLE_BITS  (SAMPLE_BITS)
) u_acs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .mux_select_o   (mux_select_o),
  .next_channel_o (next_channel_o),
  .read_data_o    (read_data_o)
);

// ===== tb/sv/tb_adc_channel_scanner_with_ema_unit.sv =====
module tb_adc_channel_scanner_with_ema_unit;

  import acs_pkg::*;

  localparam int unsigned NUM_CH   = 11;
  localparam int unsigned SAMPLE_W = 10;

  // longest quiet stretch a correct run can show is the receiver hold-off
  localparam int HOLD_CYCLES    = 300;
  localparam int QUIET_LIMIT    = 2000;
  // a conversion sweeps up to NUM_CH channels plus pipeline overhead
  localparam int DRAIN_CYCLES   = 2 * (NUM_CH + 3);
  localparam int PHASES         = 8;
  localparam int ITEMS_PER_PHASE = 60;

  typedef struct packed {
    logic [CHAN_W-1:0]   mux;
    logic [CHAN_W-1:0]   chan;
    logic [SAMPLE_W-1:0] rdata;
    logic                stalled;
  } scan_result_t;

  typedef enum logic {
    ROW_REQ,
    ROW_CFG
  } row_kind_e;

  // one row of the directed stimulus: a request or an enable write,
  // with the expected response typed in where pinned is set
  typedef struct packed {
    row_kind_e           kind;
    logic                op;
    logic [SAMPLE_W-1:0] sample;
    logic [CHAN_W-1:0]   rch;
    logic [NUM_CH-1:0]   enable;
    logic                pinned;
    logic [CHAN_W-1:0]   e_mux;
    logic [CHAN_W-1:0]   e_chan;
    logic [SAMPLE_W-1:0] e_rdata;
    logic                e_stall;
  } dir_row_t;

  localparam int DIR_ROWS = 31;

  // state after reset: channel 0 selected, only the smoothed channel enabled
  dir_row_t dir_table [DIR_ROWS] = '{
    // reads right after reset, including a channel beyond the last
    '{ROW_REQ, OP_READ,    10'd0,    4'd0,  11'd0, 1'b1, 4'd0,  4'd0,  10'd0,    1'b0},
    '{ROW_REQ, OP_READ,    10'd1023, 4'd15, 11'd0, 1'b1, 4'd0,  4'd0,  10'd0,    1'b0},
    // full-scale sample on channel 0, scan jumps to the smoothed channel
    '{ROW_REQ, OP_CONVERT, 10'd1023, 4'd0,  11'd0, 1'b1, 4'd7,  4'd7,  10'd0,    1'b0},
    '{ROW_REQ, OP_READ,    10'd0,    4'd0,  11'd0, 1'b1, 4'd7,  4'd7,  10'd1023, 1'b0},
    // first average from zero, scan wraps back onto the only enabled channel
    '{ROW_REQ, OP_CONVERT, 10'd1023, 4'd0,  11'd0, 1'b1, 4'd7,  4'd7,  10'd0,    1'b0},
    '{ROW_REQ, OP_READ,    10'd0,    4'd7,  11'd0, 1'b1, 4'd7,  4'd7,  10'd127,  1'b0},
    '{ROW_REQ, OP_CONVERT, 10'd0,    4'd0,  11'd0, 1'b0, 4'd0,  4'd0,  10'd0,    1'b0},
    '{ROW_REQ, OP_CONVERT, 10'd1023, 4'd0,  11'd0, 1'b0, 4'd0,  4'd0,  10'd0,    1'b0},
    // all channels: walk through the temperature boundary and the wrap
    '{ROW_CFG, OP_CONVERT, 10'd0,    4'd0, 11'h7FF, 1'b0, 4'd0,  4'd0,  10'd0,    1'b0},
    '{ROW_REQ, OP_CONVERT, 10'd5,    4'd0,  11'd0, 1'b0, 4'd0,  4'd0,  10'd0,    1'b0},
    '{ROW_REQ, OP_CONVERT, 10'd512,  4'd0,  11'd0, 1'b1, 4'd14, 4'd9,  10'd0,    1'b0},
    '{ROW_REQ, OP_CONVERT, 10'd1,    4'd0,  11'd0, 1'b1, 4'd15, 4'd10, 10'd0,    1'b0},
    '{ROW_REQ, OP_CONVERT, 10'd2,    4'd0,  11'd0, 1'b1, 4'd0,  4'd0,  10'd0,    1'b0},
    '{ROW_REQ, OP_READ,    10'd0,    4'd10, 11'd0, 1'b1, 4'd0,  4'd0,  10'd2,    1'b0},
    '{ROW_REQ, OP_READ,    10'd0,    4'd8,  11'd0, 1'b1, 4'd0,  4'd0,  10'd512,  1'b0},
    // empty mask: sample stored, channel kept, stall flagged
    '{ROW_CFG, OP_CONVERT, 10'd0,    4'd0,  11'h000, 1'b0, 4'd0, 4'd0, 10'd0,    1'b0},
    '{ROW_REQ, OP_CONVERT, 10'd300,  4'd0,  11'd0, 1'b1, 4'd0,  4'd0,  10'd0,    1'b1},
    '{ROW_REQ, OP_READ,    10'd0,    4'd0,  11'd0, 1'b1, 4'd0,  4'd0,  10'd300,  1'b0},
    // last channel only
    '{ROW_CFG, OP_CONVERT, 10'd0,    4'd0,  11'h400, 1'b0, 4'd0, 4'd0, 10'd0,    1'b0},
    '{ROW_REQ, OP_CONVERT, 10'd77,   4'd0,  11'd0, 1'b1, 4'd15, 4'd10, 10'd0,    1'b0},
    '{ROW_REQ, OP_CONVERT, 10'd1023, 4'd0,  11'd0, 1'b1, 4'd15, 4'd10, 10'd0,    1'b0},
    // first channel only
    '{ROW_CFG, OP_CONVERT, 10'd0,    4'd0,  11'h001, 1'b0, 4'd0, 4'd0, 10'd0,    1'b0},
    '{ROW_REQ, OP_CONVERT, 10'd0,    4'd0,  11'd0, 1'b1, 4'd0,  4'd0,  10'd0,    1'b0},
    '{ROW_REQ, OP_READ,    10'd0,    4'd11, 11'd0, 1'b1, 4'd0,  4'd0,  10'd0,    1'b0},
    '{ROW_REQ, OP_READ,    10'd1023, 4'd5,  11'd0, 1'b1, 4'd0,  4'd0,  10'd0,    1'b0},
    // smoothing still applies on a conversion that stalls the scan
    '{ROW_CFG, OP_CONVERT, 10'd0,    4'd0,  11'h080, 1'b0, 4'd0, 4'd0, 10'd0,    1'b0},
    '{ROW_REQ, OP_CONVERT, 10'd1023, 4'd0,  11'd0, 1'b0, 4'd0,  4'd0,  10'd0,    1'b0},
    '{ROW_CFG, OP_CONVERT, 10'd0,    4'd0,  11'h000, 1'b0, 4'd0, 4'd0, 10'd0,    1'b0},
    '{ROW_REQ, OP_CONVERT, 10'd1023, 4'd0,  11'd0, 1'b0, 4'd0,  4'd0,  10'd0,    1'b0},
    '{ROW_REQ, OP_READ,    10'd0,    4'd7,  11'd0, 1'b0, 4'd0,  4'd0,  10'd0,    1'b0},
    '{ROW_REQ, OP_READ,    10'd0,    4'd0,  11'd0, 1'b0, 4'd0,  4'd0,  10'd0,    1'b0}
  };

  // clock, reset and block ports
  logic                clk_i                = 1'b0;
  logic                rst_ni               = 1'b0;
  logic                in_valid_i           = 1'b0;
  logic                in_stall_o;
  logic                op_i                 = OP_CONVERT;
  logic [SAMPLE_W-1:0] sample_i             = '0;
  logic [CHAN_W-1:0]   read_channel_i       = '0;
  logic                out_valid_o;
  logic                out_stall_i          = 1'b0;
  logic [CHAN_W-1:0]   mux_select_o;
  logic [CHAN_W-1:0]   next_channel_o;
  logic [SAMPLE_W-1:0] read_data_o;
  logic                scan_stalled_o;
  logic                cfg_valid_i          = 1'b0;
  logic                cfg_ready_o;
  logic [NUM_CH-1:0]   cfg_channel_enable_i = '0;

  // typed-in expectation travels alongside the request payload
  logic         req_pinned  = 1'b0;
  scan_result_t req_pin_res = '0;

  // scan sequencer shadow state
  logic [CHAN_W-1:0]   scan_ch = '0;
  logic [SAMPLE_W-1:0] stored_result [NUM_CH] = '{default: '0};
  logic [SAMPLE_W-1:0] ema_value = '0;
  logic [NUM_CH-1:0]   en_mask = ENABLE_RESET[NUM_CH-1:0];

  scan_result_t expected_scans [$];
  int           mismatches = 0;

  // idling knobs, percent per cycle
  int idle_pct  = 0;
  int stall_pct = 0;

  // long receiver hold-off, requested by toggling hold_req
  logic hold_req  = 1'b0;
  logic hold_ack  = 1'b0;
  int   hold_left = 0;

  int quiet_cycles = 0;

  adc_channel_scanner_with_ema_unit #(
    .NUM_CHANNELS(NUM_CH),
    .SAMPLE_BITS (SAMPLE_W)
  ) dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .op_i                (op_i),
    .sample_i            (sample_i),
    .read_channel_i      (read_channel_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .mux_select_o        (mux_select_o),
    .next_channel_o      (next_channel_o),
    .read_data_o         (read_data_o),
    .scan_stalled_o      (scan_stalled_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_channel_enable_i(cfg_channel_enable_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // one request through the shadow sequencer: a read of the store, or store, smooth, advance scan
  function automatic scan_result_t predict_scan_step(
    input logic                op,
    input logic [SAMPLE_W-1:0] smp,
    input logic [CHAN_W-1:0]   rch
  );
    scan_result_t      res;
    logic [13:0]       acc;
    logic [CHAN_W-1:0] c;
    logic              found;
    res = '0;
    if (op == OP_READ) begin
      if (rch < NUM_CH) begin
        res.rdata = stored_result[rch];
      end
    end else begin
      if (scan_ch == SMOOTH_CH) begin
        // floor((sample + 7*old) / 8), 14 bits hold the full sum
        acc = smp + 14'd7 * ema_value;
        ema_value = acc[12:3];
        stored_result[scan_ch] = acc[12:3];
      end else begin
        stored_result[scan_ch] = smp;
      end
      if (en_mask == '0) begin
        res.stalled = 1'b1;
      end else begin
        c = scan_ch;
        found = 1'b0;
        for (int i = 0; i < NUM_CH; i++) begin
          if (!found) begin
            c = (c + 1 >= NUM_CH) ? '0 : c + 1'b1;
            found = en_mask[c];
          end
        end
        scan_ch = c;
      end
    end
    res.chan = scan_ch;
    // channels past the temperature sensor sit higher on the mux
    res.mux = (scan_ch <= TEMP_CH) ? scan_ch : scan_ch + MUX_OFFSET;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // request side: predict at acceptance; response side: compare with oldest
  always @(posedge clk_i) begin
    scan_result_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        want = predict_scan_step(op_i, sample_i, read_channel_i);
        if (req_pinned) begin
          want = req_pin_res;
        end
        expected_scans.push_back(want);
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_scans.size() == 0) begin
          report_mismatch("unexpected response, next_channel", int'(next_channel_o), 0);
        end else begin
          want = expected_scans.pop_front();
          if (mux_select_o !== want.mux) begin
            report_mismatch("mux_select", int'(mux_select_o), int'(want.mux));
          end
          if (next_channel_o !== want.chan) begin
            report_mismatch("next_channel", int'(next_channel_o), int'(want.chan));
          end
          if (read_data_o !== want.rdata) begin
            report_mismatch("read_data", int'(read_data_o), int'(want.rdata));
          end
          if (scan_stalled_o !== want.stalled) begin
            report_mismatch("scan_stalled", int'(scan_stalled_o), int'(want.stalled));
          end
        end
      end
    end
  end

  // receiver: random stall, or a long counted hold-off when asked
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack    <= hold_req;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("adc_channel_scanner_with_ema_unit regression: fail");
      $finish;
    end
  end

  // called at a rising edge; returns at the edge that takes the request
  task automatic send_request(
    input logic                op,
    input logic [SAMPLE_W-1:0] smp,
    input logic [CHAN_W-1:0]   rch,
    input logic                pin,
    input scan_result_t        pin_res
  );
    in_valid_i     <= 1'b1;
    op_i           <= op;
    sample_i       <= smp;
    read_channel_i <= rch;
    req_pinned     <= pin;
    req_pin_res    <= pin_res;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic sender_gap;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // drop valid and wait until every response is back and the block is free
  task automatic wait_idle;
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_scans.size() != 0 || in_stall_o);
  endtask

  task automatic write_enable(input logic [NUM_CH-1:0] val);
    wait_idle();
    cfg_valid_i          <= 1'b1;
    cfg_channel_enable_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    en_mask = val;
  endtask

  // random request: reads about a third of the time, extreme samples often
  task automatic send_random;
    logic                op;
    logic [SAMPLE_W-1:0] smp;
    logic [CHAN_W-1:0]   rch;
    op = ($urandom_range(99) < 35) ? OP_READ : OP_CONVERT;
    case ($urandom_range(7))
      0:       smp = '0;
      1:       smp = '1;
      default: smp = SAMPLE_W'($urandom);
    endcase
    rch = ($urandom_range(4) == 0) ? CHAN_W'($urandom_range(15))
                                   : CHAN_W'($urandom_range(NUM_CH - 1));
    send_request(op, smp, rch, 1'b0, '0);
    sender_gap();
  endtask

  initial begin
    dir_row_t          row;
    logic [NUM_CH-1:0] en;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed rows, back to back
    for (int r = 0; r < DIR_ROWS; r++) begin
      row = dir_table[r];
      if (row.kind == ROW_CFG) begin
        write_enable(row.enable);
      end else begin
        send_request(row.op, row.sample, row.rch, row.pinned,
                     scan_result_t'({row.e_mux, row.e_chan, row.e_rdata, row.e_stall}));
      end
    end

    // random phases, each with its own enable mask and idling mix
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       en = '1;
        2:       en = '0;
        4:       en = 11'h001;
        5:       en = 11'h400;
        6:       en = 11'd1 << $urandom_range(NUM_CH - 1);
        default: begin
          en = NUM_CH'($urandom);
          // keep the smoothed channel in the scan more often than not
          if ($urandom_range(1)) begin
            en[SMOOTH_CH] = 1'b1;
          end
        end
      endcase
      write_enable(en);
      case (p % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 65; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 65; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // receiver holds off while requests keep coming, block fills up
        if (p == 0 && n == 20) begin
          hold_req <= ~hold_req;
        end
        // sender waits for everything outstanding to drain
        if (n == 40) begin
          wait_idle();
        end
        send_random();
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_scans.size() == 0) begin
      $display("adc_channel_scanner_with_ema_unit regression: pass");
    end else begin
      $display("adc_channel_scanner_with_ema_unit regression: fail");
    end
    $finish;
  end

endmodule
